### rtl/core/flht_pkg.sv
// package for the free list handle table: sizes, action and status codes,
// memory entry and result types; depends on nothing
package flht_pkg;

    localparam int SLOTS       = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int RVAL_W   = 32;
    localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW       = AW + 1;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = LW + 1 + VALUE_WIDTH;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd2;

    localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);

    typedef struct packed {
        logic [LW-1:0]          link;
        logic                   used;
        logic [VALUE_WIDTH-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   handle;
        logic [RVAL_W-1:0]   read_value;
        logic                in_use;
        logic [COUNT_W-1:0]  used_count;
    } result_t;

endpackage

### rtl/core/flht_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module flht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/flht_engine.sv
// read-modify-write engine: free list head, occupancy, entry valid bits and
// the slot memory; depends on flht_pkg and flht_ram
module flht_engine (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  flht_pkg::action_t           in_action,
    input  logic [flht_pkg::SLOT_W-1:0] in_slot,
    input  logic [31:0]                 in_payload,
    output logic                        res_valid,
    input  logic                        res_ready,
    output flht_pkg::result_t           res
);
    import flht_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                 state_reg;
    action_t                act_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [VALUE_WIDTH-1:0] pay_reg;
    logic [AW-1:0]          addr_reg;
    logic [LW-1:0]          head_reg, head_next;
    logic [COUNT_W-1:0]     occ_reg, occ_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;

    logic [AW-1:0]      new_addr, rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             entry, wr_entry;
    logic               wr_req, wr_en, fire, accept, in_range;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == ST_EXEC) && res_ready;
    assign res_valid = (state_reg == ST_EXEC);

    // add looks at the head of the free list, everything else at the slot
    assign new_addr = (in_action == ACT_ADD) ? AW'(head_reg) : AW'(in_slot);
    assign rd_addr  = (state_reg == ST_IDLE) ? new_addr : addr_reg;
    assign in_range = (32'(slot_reg) < 32'(SLOTS));

    flht_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(addr_reg),
        .wr_data(wr_entry),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // an entry never written since reset or clear holds its reset contents
    always_comb begin
        if (valid_reg[addr_reg]) begin
            entry = entry_t'(rd_data);
        end else begin
            entry.link  = LW'(addr_reg) + LW'(1);
            entry.used  = 1'b0;
            entry.value = '0;
        end
    end

    always_comb begin
        wr_req     = 1'b0;
        wr_entry   = entry;
        head_next  = head_reg;
        occ_next   = occ_reg;
        valid_next = valid_reg;
        res.status     = STAT_OK;
        res.handle     = slot_reg;
        res.read_value = '0;
        res.in_use     = 1'b0;
        case (act_reg)
            ACT_ADD: begin
                if (head_reg == LINK_NULL) begin
                    res.status = STAT_FULL;
                end else begin
                    wr_req         = 1'b1;
                    wr_entry.used  = 1'b1;
                    wr_entry.value = pay_reg;
                    head_next      = entry.link;
                    if (occ_reg < COUNT_W'(SLOTS)) begin
                        occ_next = occ_reg + COUNT_W'(1);
                    end
                    res.handle = SLOT_W'(head_reg);
                end
            end
            ACT_REMOVE: begin
                if (in_range && entry.used) begin
                    wr_req         = 1'b1;
                    wr_entry.link  = head_reg;
                    wr_entry.used  = 1'b0;
                    wr_entry.value = '0;
                    head_next      = LW'(slot_reg);
                    if (occ_reg != '0) begin
                        occ_next = occ_reg - COUNT_W'(1);
                    end
                end else begin
                    res.status = STAT_NOT_USED;
                end
            end
            ACT_READ: begin
                if (in_range) begin
                    res.read_value = RVAL_W'(entry.value);
                    res.in_use     = entry.used;
                end
            end
            default: begin
                // clear: drop every valid bit, entries fall back to the chain
                valid_next = '0;
                head_next  = '0;
                occ_next   = '0;
            end
        endcase
        if (wr_req) begin
            valid_next[addr_reg] = 1'b1;
        end
        res.used_count = occ_next;
    end

    assign wr_en = fire && wr_req;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
            valid_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        state_reg <= ST_IDLE;
                        head_reg  <= head_next;
                        occ_reg   <= occ_next;
                        valid_reg <= valid_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            act_reg  <= in_action;
            slot_reg <= in_slot;
            pay_reg  <= VALUE_WIDTH'(in_payload);
            addr_reg <= new_addr;
        end
    end

endmodule

### rtl/core/free_list_handle_table_top.sv
// top level of the free list handle table: engine plus output register
// depends on flht_pkg and flht_engine
//
//  channel  | direction | fields
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | action, slot, payload
//  m_       | out       | status, handle, read_value, in_use, used_count
//
// every item, clear included, is handled in order: the slot memory is read as
// the item is accepted, then the entry is modified, written back and loaded
// into the output register; the registered read data of the slot ram sets that order.
// reset clears the entry valid bits at once, so there is no clearing sweep.
// a stalled result waits in the output register; the next item is taken
// meanwhile and holds in its write-back step until the register frees.
module free_list_handle_table_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [flht_pkg::SLOT_W-1:0]     s_slot,
    input  logic [31:0]                     s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [flht_pkg::STATUS_W-1:0]   m_status,
    output logic [flht_pkg::SLOT_W-1:0]     m_handle,
    output logic [flht_pkg::RVAL_W-1:0]     m_read_value,
    output logic                            m_in_use,
    output logic [flht_pkg::COUNT_W-1:0]    m_used_count
);
    import flht_pkg::*;

    logic    res_valid, res_ready, m_valid_reg;
    result_t res, out_reg;

    assign res_ready = !m_valid_reg || m_ready;

    flht_engine u_engine (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_action (action_t'(s_action)),
        .in_slot   (s_slot),
        .in_payload(s_payload),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_handle     = out_reg.handle;
    assign m_read_value = out_reg.read_value;
    assign m_in_use     = out_reg.in_use;
    assign m_used_count = out_reg.used_count;

    // one item at a time inside the engine
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while engine busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_used_count <= COUNT_W'(SLOTS))
        else $error("used count beyond table size");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_used_count == COUNT_W'(SLOTS))
        else $error("full reported with free slots left");

    a_in_use_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_use |-> m_status == STAT_OK)
        else $error("used bit reported with error status");

endmodule

### sim/tb_top.sv
// testbench for free_list_handle_table_top: directed and random table operations
// checked against a behavioral copy of the slot table; depends on flht_pkg and free_list_handle_table_top
module tb_top;
    import flht_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        action_t     act;
        logic [5:0]  slot;
        logic [31:0] payload;
        bit          drain_first;
    } table_op_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action     = 2'd0;
    logic [5:0]  s_slot       = 6'd0;
    logic [31:0] s_payload    = 32'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_handle;
    logic [RVAL_W-1:0]   m_read_value;
    logic                m_in_use;
    logic [COUNT_W-1:0]  m_used_count;

    table_op_t op_queue[$];
    result_t   expected_results[$];

    // behavioral copy of the table
    logic [LW-1:0]          link_mem [SLOTS];
    logic                   used_mem [SLOTS];
    logic [VALUE_WIDTH-1:0] value_mem [SLOTS];
    logic [LW-1:0]          free_top;
    logic [COUNT_W-1:0]     used_total;

    int  err_count   = 0;
    int  stall_count = 0;
    int  neg_cycles  = 0;
    bit  item_took   = 1'b0;

    free_list_handle_table_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_slot       (s_slot),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_handle     (m_handle),
        .m_read_value (m_read_value),
        .m_in_use     (m_in_use),
        .m_used_count (m_used_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void table_rebuild();
        for (int i = 0; i < SLOTS; i++) begin
            link_mem[i]  = LW'(i + 1);
            used_mem[i]  = 1'b0;
            value_mem[i] = '0;
        end
        free_top   = '0;
        used_total = '0;
    endfunction

    function automatic result_t table_apply(input action_t act, input logic [5:0] idx,
                                            input logic [31:0] pay);
        result_t r;
        r.status     = STAT_OK;
        r.handle     = idx;
        r.read_value = '0;
        r.in_use     = 1'b0;
        case (act)
            ACT_ADD: begin
                if (free_top >= LINK_NULL) begin
                    r.status = STAT_FULL;
                end else begin
                    value_mem[free_top[AW-1:0]] = pay;
                    used_mem[free_top[AW-1:0]]  = 1'b1;
                    r.handle = free_top[AW-1:0];
                    free_top = link_mem[free_top[AW-1:0]];
                    if (used_total < SLOTS) used_total++;
                end
            end
            ACT_REMOVE: begin
                if (used_mem[idx]) begin
                    link_mem[idx]  = free_top;
                    free_top       = {1'b0, idx};
                    used_mem[idx]  = 1'b0;
                    value_mem[idx] = '0;
                    if (used_total > 0) used_total--;
                end else begin
                    r.status = STAT_NOT_USED;
                end
            end
            ACT_READ: begin
                r.read_value = value_mem[idx];
                r.in_use     = used_mem[idx];
            end
            default: begin
                table_rebuild();
            end
        endcase
        r.used_count = used_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    task automatic queue_op(input action_t act, input logic [5:0] slot,
                            input logic [31:0] pay, input bit drain_first);
        table_op_t op;
        op.act         = act;
        op.slot        = slot;
        op.payload     = pay;
        op.drain_first = drain_first;
        op_queue.push_back(op);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        neg_cycles <= neg_cycles + 1;
        // long calm window with no idling on either side
        if (neg_cycles >= 1200 && neg_cycles < 2200)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 99) >= 28);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !item_took) begin
            // item still waiting for ready
        end else if (op_queue.size() != 0
                     && !(op_queue[0].drain_first && expected_results.size() != 0)
                     && ((neg_cycles >= 1200 && neg_cycles < 2200)
                         || $urandom_range(0, 99) >= 28)) begin
            s_valid   <= 1'b1;
            s_action  <= op_queue[0].act;
            s_slot    <= op_queue[0].slot;
            s_payload <= op_queue[0].payload;
            void'(op_queue.pop_front());
        end else begin
            s_valid <= 1'b0;
        end
    end

    // monitor: sample both channels on the rising edge
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            item_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, handle", 32'(m_handle), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_handle !== want.handle)
                        report_mismatch("handle", 32'(m_handle), 32'(want.handle));
                    if (m_read_value !== want.read_value)
                        report_mismatch("read_value", m_read_value, want.read_value);
                    if (m_in_use !== want.in_use)
                        report_mismatch("in_use", 32'(m_in_use), 32'(want.in_use));
                    if (m_used_count !== want.used_count)
                        report_mismatch("used_count", 32'(m_used_count),
                                        32'(want.used_count));
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(table_apply(action_t'(s_action), s_slot,
                                                       s_payload));
        end else begin
            item_took <= 1'b0;
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int total;
        int span;
        int mode;
        int pick;
        int blocks;
        action_t act;
        table_rebuild();

        // directed: free reads, bad removes, reuse of freed slots, clear
        queue_op(ACT_READ,   6'd0,  32'h0, 1'b0);
        queue_op(ACT_REMOVE, 6'd5,  32'h0, 1'b0);
        queue_op(ACT_ADD,    6'd63, 32'h0000_0000, 1'b0);
        queue_op(ACT_ADD,    6'd0,  32'hFFFF_FFFF, 1'b0);
        queue_op(ACT_ADD,    6'd21, 32'hA5A5_5A5A, 1'b0);
        queue_op(ACT_READ,   6'd1,  32'h0, 1'b0);
        queue_op(ACT_READ,   6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_op(ACT_REMOVE, 6'd1,  32'h0, 1'b0);
        queue_op(ACT_REMOVE, 6'd1,  32'h0, 1'b0);
        queue_op(ACT_READ,   6'd1,  32'h0, 1'b0);
        queue_op(ACT_ADD,    6'd42, 32'h1234_5678, 1'b0);
        queue_op(ACT_REMOVE, 6'd0,  32'h0, 1'b0);
        queue_op(ACT_REMOVE, 6'd2,  32'h0, 1'b0);
        queue_op(ACT_ADD,    6'd0,  32'h8000_0001, 1'b0);
        queue_op(ACT_ADD,    6'd0,  32'h7FFF_FFFE, 1'b0);
        queue_op(ACT_READ,   6'd2,  32'h0, 1'b0);
        queue_op(ACT_CLEAR,  6'd63, 32'hFFFF_FFFF, 1'b0);
        queue_op(ACT_READ,   6'd1,  32'h0, 1'b0);
        queue_op(ACT_ADD,    6'd63, 32'hDEAD_BEEF, 1'b0);
        queue_op(ACT_CLEAR,  6'd0,  32'h0, 1'b0);
        queue_op(ACT_READ,   6'd0,  32'h0, 1'b0);

        // random: fill, drain and mixed bursts so the table hits full and empty
        total  = 0;
        blocks = 0;
        while (total < 1030) begin
            span = $urandom_range(20, 90);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < span; k++) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0: act = (pick < 88) ? ACT_ADD : (pick < 97) ? ACT_READ : ACT_REMOVE;
                    1: act = (pick < 65) ? ACT_REMOVE : (pick < 88) ? ACT_READ : ACT_ADD;
                    default: act = (pick < 40) ? ACT_ADD : (pick < 73) ? ACT_REMOVE
                                 : (pick < 97) ? ACT_READ : ACT_CLEAR;
                endcase
                queue_op(act, 6'($urandom_range(0, 63)), $urandom,
                         (k == 0) && (blocks % 4 == 0));
            end
            total  += span;
            blocks++;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (op_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
